@@ sv/lbac_pkg.sv @@
// Types and constants shared by the label-indexed bin accumulator.
package lbac_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int LABEL_WIDTH     = 9;
  localparam int INDEX_WIDTH     = 4;
  localparam int VLEN_WIDTH      = 5;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 9;

  localparam int DEF_MAX_LABELS     = 256;
  localparam int DEF_MAX_VECTOR_LEN = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORIENT_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NUM_LABELS     = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VECTOR_LEN     = 2'd2;

  localparam logic FUNC_ACCUMULATE = 1'b0;
  localparam logic FUNC_READ_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LABEL = 2'd1,
    ST_BAD_POS   = 2'd2
  } status_t;

  typedef struct packed {
    logic                          func;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [LABEL_WIDTH-1:0]        label;
    logic [INDEX_WIDTH-1:0]        row_index;
    logic [INDEX_WIDTH-1:0]        col_index;
  } in_item_t;

  typedef struct packed {
    status_t                       status;
    logic signed [VALUE_WIDTH-1:0] bin_value;
  } out_item_t;

endpackage

@@ sv/label_indexed_bin_accumulator_unit.sv @@
// Label-indexed bin accumulator: scatter-add into bins addressed by (label, position).
//
// Input channel (in_valid/in_stall/in_data) takes one item per transfer: an
// accumulate adds value into its bin and returns the new sum, a read returns
// the bin and zeroes it. Bad label or position gives an error status, value 0,
// and leaves the store alone. Every item yields exactly one result on the
// output channel (out_valid/out_stall/out_data), in order.
// out_valid rises after the item passes the read stage into the output
// register. One item per cycle is sustained while the output is not stalled:
// the bin RAM is read on acceptance and written back as the item leaves the
// read stage, with a bypass register covering back-to-back hits on the same bin.
// After reset the block sweeps the bin RAM to zero, one entry per cycle, over
// all MAX_LABELS * MAX_VECTOR_LEN entries (4096 by default); in_stall stays high
// until the sweep ends. Configuration writes are taken at any time and should
// only be issued while the block is idle.
// When out_stall is high the result holds in the output register; one more
// item can sit in the read stage, after which in_stall rises.
module label_indexed_bin_accumulator_unit #(
  parameter int MAX_LABELS     = lbac_pkg::DEF_MAX_LABELS,
  parameter int MAX_VECTOR_LEN = lbac_pkg::DEF_MAX_VECTOR_LEN
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lbac_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lbac_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [lbac_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lbac_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import lbac_pkg::*;

  localparam int BIN_COUNT = MAX_LABELS * MAX_VECTOR_LEN;
  localparam int ADDR_W    = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'b01,
    MODE_RUN   = 2'b10
  } mode_t;

  mode_t                  mode;
  logic [ADDR_W-1:0]      clear_cnt;

  logic                   orient_columns;
  logic [LABEL_WIDTH-1:0] num_labels;
  logic [VLEN_WIDTH-1:0]  vector_len;

  status_t                chk_status;
  logic [ADDR_W-1:0]      chk_addr;

  logic                   s1_valid;
  logic                   s1_func;
  logic [VALUE_WIDTH-1:0] s1_value;
  status_t                s1_status;
  logic [ADDR_W-1:0]      s1_addr;
  logic                   s1_fwd;
  logic [VALUE_WIDTH-1:0] s1_fwd_data;

  logic [VALUE_WIDTH-1:0] rd_data;
  logic [VALUE_WIDTH-1:0] cur_bin;
  logic [VALUE_WIDTH-1:0] sum;
  logic [VALUE_WIDTH-1:0] bin_next;
  logic [VALUE_WIDTH-1:0] result;

  logic                   s1_go;
  logic                   accept;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      orient_columns <= 1'b1;
      num_labels     <= LABEL_WIDTH'(256);
      vector_len     <= VLEN_WIDTH'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIENT_COLUMNS: orient_columns <= cfg_data[0];
        CFG_NUM_LABELS:     num_labels     <= cfg_data[LABEL_WIDTH-1:0];
        CFG_VECTOR_LEN:     vector_len     <= cfg_data[VLEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  lbac_addr_check #(
    .MAX_LABELS    (MAX_LABELS),
    .MAX_VECTOR_LEN(MAX_VECTOR_LEN),
    .ADDR_W        (ADDR_W)
  ) u_check (
    .item          (in_data),
    .orient_columns(orient_columns),
    .num_labels    (num_labels),
    .vector_len    (vector_len),
    .status        (chk_status),
    .addr          (chk_addr)
  );

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_CLEAR;
      clear_cnt <= '0;
    end else begin
      unique case (mode)
        MODE_CLEAR: begin
          clear_cnt <= clear_cnt + ADDR_W'(1);
          if (clear_cnt == ADDR_W'(BIN_COUNT - 1)) begin
            mode <= MODE_RUN;
          end
        end
        MODE_RUN: ;
        default: mode <= MODE_CLEAR;
      endcase
    end
  end

  always_comb begin
    s1_go    = s1_valid && (!out_valid || !out_stall);
    accept   = in_valid && !in_stall;
    in_stall = !((mode == MODE_RUN) && (!s1_valid || s1_go));

    cur_bin  = s1_fwd ? s1_fwd_data : rd_data;
    sum      = cur_bin + s1_value;
    bin_next = (s1_func == FUNC_ACCUMULATE) ? sum : '0;
    if (s1_status != ST_OK) begin
      result = '0;
    end else if (s1_func == FUNC_ACCUMULATE) begin
      result = sum;
    end else begin
      result = cur_bin;
    end

    if (mode == MODE_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clear_cnt;
      wr_data = '0;
    end else begin
      wr_en   = s1_go && (s1_status == ST_OK);
      wr_addr = s1_addr;
      wr_data = bin_next;
    end
  end

  lbac_bin_ram #(
    .DEPTH (BIN_COUNT),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(chk_addr),
    .rd_data(rd_data)
  );

  // read stage: holds the item whose bin read is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      // bypass: the item ahead writes this bin on the same edge as our read
      s1_fwd   <= s1_valid && (s1_status == ST_OK) && (chk_status == ST_OK)
               && (s1_addr == chk_addr);
    end else if (s1_go) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func     <= in_data.func;
      s1_value    <= in_data.value;
      s1_status   <= chk_status;
      s1_addr     <= chk_addr;
      s1_fwd_data <= bin_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data.status    <= s1_status;
      out_data.bin_value <= result;
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_CLEAR) |-> in_stall)
    else $error("input transfer during clearing sweep");

  a_error_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != ST_OK)) |-> (out_data.bin_value == '0))
    else $error("error result carries a non-zero bin value");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> (s1_valid && (s1_status == ST_OK)))
    else $error("bypass flag set without a valid in-range item");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_addr) && $stable(rd_data)))
    else $error("read stage lost its item or bin data while stalled");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_RUN && wr_en) |-> (s1_valid && (s1_status == ST_OK)))
    else $error("bin write without an item in the read stage");

endmodule

@@ sv/lbac_bin_ram.sv @@
// Bin store: single write port, one registered read port.
module lbac_bin_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [lbac_pkg::VALUE_WIDTH-1:0] wr_data,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  output logic [lbac_pkg::VALUE_WIDTH-1:0] rd_data
);
  import lbac_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write: a same-address write lands after this read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/lbac_addr_check.sv @@
// Range checks on label and position, and bin address generation.
module lbac_addr_check #(
  parameter int MAX_LABELS     = 256,
  parameter int MAX_VECTOR_LEN = 16,
  parameter int ADDR_W         = 12
) (
  input  lbac_pkg::in_item_t                 item,
  input  logic                               orient_columns,
  input  logic [lbac_pkg::LABEL_WIDTH-1:0]   num_labels,
  input  logic [lbac_pkg::VLEN_WIDTH-1:0]    vector_len,
  output lbac_pkg::status_t                  status,
  output logic [ADDR_W-1:0]                  addr
);
  import lbac_pkg::*;

  localparam int LBL_CMP_W = 17;
  localparam int POS_CMP_W = 13;
  localparam int PROD_W    = (ADDR_W > LABEL_WIDTH + POS_CMP_W) ? ADDR_W
                                                                : LABEL_WIDTH + POS_CMP_W;

  logic [INDEX_WIDTH-1:0] pos;
  logic [LABEL_WIDTH-1:0] lbl_idx;
  logic                   bad_label;
  logic                   bad_pos;
  logic [PROD_W-1:0]      addr_full;

  always_comb begin
    pos     = orient_columns ? item.row_index : item.col_index;
    lbl_idx = item.label - LABEL_WIDTH'(1);

    bad_label = (item.label == '0) || (item.label > num_labels)
             || ({{(LBL_CMP_W-LABEL_WIDTH){1'b0}}, item.label} > LBL_CMP_W'(MAX_LABELS));
    bad_pos   = ({1'b0, pos} >= vector_len)
             || ({{(POS_CMP_W-INDEX_WIDTH){1'b0}}, pos} >= POS_CMP_W'(MAX_VECTOR_LEN));

    if (bad_label) begin
      status = ST_BAD_LABEL;
    end else if (bad_pos) begin
      status = ST_BAD_POS;
    end else begin
      status = ST_OK;
    end

    addr_full = PROD_W'(lbl_idx) * PROD_W'(MAX_VECTOR_LEN) + PROD_W'(pos);
    addr      = addr_full[ADDR_W-1:0];
  end

endmodule
